// File: hw/rtl/jbce_pkg.sv
// Package for the JTAG byte command engine: item structs, pin bit positions
// and the command descriptor passed from the front end to the back end.
// Depends on nothing; every other file references it by scoped names.
package jbce_pkg;

   // Bit positions inside a host byte (and inside the held pin levels)
   localparam int unsigned PinTck    = 0;
   localparam int unsigned PinTms    = 1;
   localparam int unsigned PinNce    = 2;
   localparam int unsigned PinNcs    = 3;
   localparam int unsigned PinTdi    = 4;
   localparam int unsigned PinLed    = 5;
   localparam int unsigned ReadBit   = 6;
   localparam int unsigned ShModeBit = 7;

   localparam int unsigned PinW   = 6;
   localparam int unsigned CountW = 6;
   localparam int unsigned ByteW  = 8;

   // Pins kept steady during a shifted byte: TMS, nCE, nCS, LED
   localparam logic [PinW-1:0] HeldMask = 6'b10_1110;

   // Sixteen pin phases per shifted byte: phase[3:1] is the bit, phase[0] TCK
   localparam int unsigned     PhaseW    = 4;
   localparam logic [PhaseW-1:0] LastPhase = 4'd15;

   // Command queue between front end and back end
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueueAddrW = 1;
   localparam int unsigned QueueCntW  = 2;

   typedef struct packed {
      logic [7:0] host_byte;
      logic [7:0] tdo_sample;
   } req_type;

   typedef struct packed {
      logic       pin_tck;
      logic       pin_tms;
      logic       pin_tdi;
      logic       pin_nce;
      logic       pin_ncs;
      logic       pin_led;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       run_last;
   } rsp_type;

   // One classified item: a single pin phase or a shifted data byte
   typedef struct packed {
      logic            is_shift;  // 1: sixteen phases from data, 0: one phase
      logic [PinW-1:0] pins;      // full pins, or held pins for a shift
      logic            rd;        // readback requested on the final phase
      logic [ByteW-1:0] data;     // byte to shift out on TDI, LSB first
      logic [ByteW-1:0] tdo;      // byte to return when rd is set
   } cmd_type;

   // Queue status seen by the front end and the back end
   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

endpackage

// File: hw/rtl/jbce_front.sv
// Front end of the JTAG byte command engine: accepts host items, tracks the
// bitbang/shift mode and held pins, and pushes one command per item.
// Depends on jbce_pkg.
module jbce_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jbce_pkg::req_type  req_item,
   input  jbce_pkg::qstat_type q_stat,
   output logic               q_push,
   output jbce_pkg::cmd_type  q_cmd
);

   logic                          shift_active_ff, shift_active_in;
   logic [jbce_pkg::CountW-1:0]   bytes_left_ff, bytes_left_in;
   logic                          read_en_ff, read_en_in;
   logic [jbce_pkg::PinW-1:0]     pins_ff, pins_in;

   logic [jbce_pkg::PinW-1:0]     held;
   logic [jbce_pkg::CountW-1:0]   hdr_count;

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready;
   assign held      = pins_ff & jbce_pkg::HeldMask;
   assign hdr_count = req_item.host_byte[jbce_pkg::CountW-1:0];

   // Classify the item and work out the next mode state
   always_comb begin
      shift_active_in = shift_active_ff;
      bytes_left_in   = bytes_left_ff;
      read_en_in      = read_en_ff;
      pins_in         = pins_ff;
      q_cmd           = '0;
      if (shift_active_ff) begin
         q_cmd.is_shift = 1'b1;
         q_cmd.pins     = held;
         q_cmd.rd       = read_en_ff;
         q_cmd.data     = req_item.host_byte;
         q_cmd.tdo      = req_item.tdo_sample;
         // last phase leaves TCK high and TDI at the top data bit
         pins_in = held;
         pins_in[jbce_pkg::PinTck] = 1'b1;
         pins_in[jbce_pkg::PinTdi] = req_item.host_byte[jbce_pkg::ByteW-1];
         bytes_left_in = bytes_left_ff - 1'b1;
         if (bytes_left_ff == jbce_pkg::CountW'(1)) begin
            shift_active_in = 1'b0;
            read_en_in      = 1'b0;
         end
      end else if (req_item.host_byte[jbce_pkg::ShModeBit]) begin
         // header: report current pins; a zero count stays in bitbang mode
         q_cmd.pins = pins_ff;
         if (hdr_count != '0) begin
            shift_active_in = 1'b1;
            bytes_left_in   = hdr_count;
            read_en_in      = req_item.host_byte[jbce_pkg::ReadBit];
         end
      end else begin
         pins_in    = req_item.host_byte[jbce_pkg::PinW-1:0];
         q_cmd.pins = req_item.host_byte[jbce_pkg::PinW-1:0];
         q_cmd.rd   = req_item.host_byte[jbce_pkg::ReadBit];
         q_cmd.tdo  = {7'b0, req_item.tdo_sample[0] & req_item.host_byte[jbce_pkg::ReadBit]};
      end
   end

   // Hold mode state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_active_ff <= 1'b0;
         bytes_left_ff   <= '0;
         read_en_ff      <= 1'b0;
         pins_ff         <= '0;
      end else if (q_push) begin
         shift_active_ff <= shift_active_in;
         bytes_left_ff   <= bytes_left_in;
         read_en_ff      <= read_en_in;
         pins_ff         <= pins_in;
      end
   end

   a_active_has_count: assert property (@(posedge clock) disable iff (reset)
      shift_active_ff |-> (bytes_left_ff != '0))
      else $error("shift mode with zero bytes left");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      !shift_active_ff |-> !read_en_ff)
      else $error("read enable kept outside shift mode");

endmodule

// File: hw/rtl/jbce_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on jbce_pkg.
module jbce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jbce_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output jbce_pkg::cmd_type   head_cmd,
   output jbce_pkg::qstat_type stat
);

   jbce_pkg::cmd_type               mem_ff [jbce_pkg::QueueDepth];
   logic [jbce_pkg::QueueAddrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [jbce_pkg::QueueCntW-1:0]  count_ff, count_in;

   assign stat.full     = (count_ff == jbce_pkg::QueueCntW'(jbce_pkg::QueueDepth));
   assign stat.nonempty = (count_ff != '0);
   assign head_cmd      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Store entries; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.nonempty)
      else $error("pop from empty queue");

endmodule

// File: hw/rtl/jbce_back.sv
// Back end of the JTAG byte command engine: expands each queued command
// into pin phases and holds them in the result output register.
// Depends on jbce_pkg.
module jbce_back (
   input  logic                clock,
   input  logic                reset,
   input  jbce_pkg::qstat_type q_stat,
   input  jbce_pkg::cmd_type   q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output jbce_pkg::rsp_type   rsp_item
);

   logic                          busy_ff, busy_in;
   jbce_pkg::cmd_type             cur_ff;
   logic [jbce_pkg::PhaseW-1:0]   phase_ff, phase_in;
   logic                          rsp_valid_ff;
   jbce_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          src_valid;
   jbce_pkg::cmd_type             src_cmd;
   logic [jbce_pkg::PhaseW-1:0]   src_phase;
   logic                          out_free;
   logic                          emit;
   logic                          fin;
   logic [2:0]                    bit_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign src_valid = busy_ff || q_stat.nonempty;
   assign src_cmd   = busy_ff ? cur_ff : q_head;
   assign src_phase = busy_ff ? phase_ff : '0;
   assign emit      = src_valid && out_free;
   assign q_pop     = emit && !busy_ff;
   assign bit_idx   = src_phase[jbce_pkg::PhaseW-1:1];
   assign fin       = !src_cmd.is_shift || (src_phase == jbce_pkg::LastPhase);

   // Build the pin phase for the current source
   always_comb begin
      rsp_in            = '0;
      rsp_in.pin_tms    = src_cmd.pins[jbce_pkg::PinTms];
      rsp_in.pin_nce    = src_cmd.pins[jbce_pkg::PinNce];
      rsp_in.pin_ncs    = src_cmd.pins[jbce_pkg::PinNcs];
      rsp_in.pin_led    = src_cmd.pins[jbce_pkg::PinLed];
      if (src_cmd.is_shift) begin
         rsp_in.pin_tck = src_phase[0];
         rsp_in.pin_tdi = src_cmd.data[bit_idx];
      end else begin
         rsp_in.pin_tck = src_cmd.pins[jbce_pkg::PinTck];
         rsp_in.pin_tdi = src_cmd.pins[jbce_pkg::PinTdi];
      end
      rsp_in.run_last   = fin;
      rsp_in.read_valid = fin && src_cmd.rd;
      rsp_in.read_byte  = (fin && src_cmd.rd) ? src_cmd.tdo : '0;
   end

   // Advance the phase counter of a shifted byte
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (emit) begin
         busy_in  = !fin;
         phase_in = src_phase + 1'b1;
      end
   end

   // Hold the command being expanded; payload needs no reset
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_busy_is_shift: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cur_ff.is_shift)
      else $error("back end busy on a single-phase command");

   a_busy_mid_phase: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (phase_ff != '0))
      else $error("back end busy at phase zero");

   a_read_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |-> rsp_ff.run_last)
      else $error("readback on a phase that is not the last");

endmodule

// File: hw/rtl/jtag_byte_command_engine.sv
// Top level of the JTAG byte command engine: front end, command queue and
// back end. Depends on jbce_pkg, jbce_front, jbce_queue and jbce_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   req_    | in        | req_valid / req_ready | req_item  (host_byte, tdo)
//   rsp_    | out       | rsp_valid / rsp_ready | rsp_item  (pins, readback)
//
// A bitbang byte or a header gives one result; a data byte in shift mode
// gives sixteen results, one pin phase per cycle while rsp_ready is high,
// set by the back end's phase counter. Items enter back to back while the
// two-entry command queue has room. Reset (synchronous) returns to bitbang
// mode with all pins low and an empty queue. A low rsp_ready holds the output
// register; the front end keeps accepting until the queue fills.
module jtag_byte_command_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  jbce_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jbce_pkg::rsp_type  rsp_item
);

   jbce_pkg::qstat_type q_stat;
   jbce_pkg::cmd_type   push_cmd;
   jbce_pkg::cmd_type   head_cmd;
   logic                q_push;
   logic                q_pop;

   jbce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   jbce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   jbce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_head    (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/testbench.sv
// Self-checking bench for jtag_byte_command_engine: directed table, then random
// host bytes, each pin phase checked against a behavioral model or a typed table row.
// Depends on jbce_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int RandItems  = 234;
   localparam int HoldCycles = 300;
   localparam int StallLimit = 3000;
   localparam int DrainWait  = 40;
   localparam int MaxReports = 10;

   typedef struct {
      logic [7:0]                host_byte;
      logic [7:0]                tdo;
      bit                        typed;  // expected phase given below, not from the model
      logic [jbce_pkg::PinW-1:0] pins;   // bit order as in a bitbang byte
      bit                        rv;
      logic [7:0]                rb;
   } dir_row_type;

   localparam int DirN = 16;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   jbce_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   jbce_pkg::rsp_type rsp_item;

   // Model state: shift mode, bytes left, readback request, held pins
   bit                          sh_active = 1'b0;
   logic [jbce_pkg::CountW-1:0] sh_left   = '0;
   bit                          sh_read   = 1'b0;
   logic [jbce_pkg::PinW-1:0]   held_pins = '0;

   jbce_pkg::rsp_type pending_phases [$];
   int                sent_cnt     = 0;
   int                phase_cnt    = 0;
   int                mismatch_cnt = 0;
   int                idle_cycles  = 0;

   dir_row_type dir_tab [DirN] = '{
      '{8'h40, 8'hFF, 1'b1, 6'h00, 1'b1, 8'h01},  // bitbang read, TDO high
      '{8'h3F, 8'h00, 1'b1, 6'h3F, 1'b0, 8'h00},  // every pin high
      '{8'h7F, 8'hFE, 1'b1, 6'h3F, 1'b1, 8'h00},  // readback ignores TDO bits 7..1
      '{8'h80, 8'hFF, 1'b1, 6'h3F, 1'b0, 8'h00},  // header, zero count
      '{8'hC0, 8'h00, 1'b1, 6'h3F, 1'b0, 8'h00},  // header, zero count, read
      '{8'h00, 8'hFF, 1'b1, 6'h00, 1'b0, 8'h00},  // every pin low
      '{8'h2A, 8'h55, 1'b1, 6'h2A, 1'b0, 8'h00},
      '{8'hC2, 8'h00, 1'b0, 6'h00, 1'b0, 8'h00},  // two bytes with readback
      '{8'hA5, 8'h5A, 1'b0, 6'h00, 1'b0, 8'h00},
      '{8'hFF, 8'hFF, 1'b0, 6'h00, 1'b0, 8'h00},  // last byte, back to bitbang
      '{8'h41, 8'h01, 1'b1, 6'h01, 1'b1, 8'h01},
      '{8'h81, 8'h00, 1'b0, 6'h00, 1'b0, 8'h00},  // one byte, no readback
      '{8'h00, 8'hFF, 1'b0, 6'h00, 1'b0, 8'h00},
      '{8'h7E, 8'h01, 1'b1, 6'h3E, 1'b1, 8'h01},
      '{8'h80, 8'h00, 1'b1, 6'h3E, 1'b0, 8'h00},  // zero count holds pins
      '{8'hFF, 8'h00, 1'b0, 6'h00, 1'b0, 8'h00}   // maximum count, readback
   };

   jtag_byte_command_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Build one pin phase from held-pin bits
   function automatic jbce_pkg::rsp_type pin_phase(logic [jbce_pkg::PinW-1:0] p, bit rv,
                                                   logic [7:0] rb, bit last);
      jbce_pkg::rsp_type r;
      r.pin_tck    = p[jbce_pkg::PinTck];
      r.pin_tms    = p[jbce_pkg::PinTms];
      r.pin_tdi    = p[jbce_pkg::PinTdi];
      r.pin_nce    = p[jbce_pkg::PinNce];
      r.pin_ncs    = p[jbce_pkg::PinNcs];
      r.pin_led    = p[jbce_pkg::PinLed];
      r.read_valid = rv;
      r.read_byte  = rv ? rb : 8'h00;
      r.run_last   = last;
      return r;
   endfunction

   // Advance the engine model by one host byte and queue its pin phases
   task automatic compute_pin_phases(input jbce_pkg::req_type it);
      logic [jbce_pkg::PinW-1:0] p;
      bit                        fin;
      if (sh_active) begin
         for (int i = 0; i < 8; i++) begin
            fin = (i == 7);
            p = held_pins & jbce_pkg::HeldMask;
            p[jbce_pkg::PinTdi] = it.host_byte[i];
            pending_phases.push_back(pin_phase(p, 1'b0, 8'h00, 1'b0));
            p[jbce_pkg::PinTck] = 1'b1;
            pending_phases.push_back(pin_phase(p, fin && sh_read, it.tdo_sample, fin));
         end
         held_pins = p;
         sh_left   = sh_left - 1'b1;
         if (sh_left == 0) begin
            sh_active = 1'b0;
            sh_read   = 1'b0;
         end
      end else if (it.host_byte[jbce_pkg::ShModeBit]) begin
         if (it.host_byte[jbce_pkg::CountW-1:0] != 0) begin
            sh_active = 1'b1;
            sh_left   = it.host_byte[jbce_pkg::CountW-1:0];
            sh_read   = it.host_byte[jbce_pkg::ReadBit];
         end
         pending_phases.push_back(pin_phase(held_pins, 1'b0, 8'h00, 1'b1));
      end else begin
         held_pins = it.host_byte[jbce_pkg::PinW-1:0];
         pending_phases.push_back(pin_phase(held_pins, it.host_byte[jbce_pkg::ReadBit],
                                            {7'd0, it.tdo_sample[0]}, 1'b1));
      end
   endtask

   // Offer one item, optionally after random gaps, and hold it until taken
   task automatic send_item(input jbce_pkg::req_type it, input bit may_idle,
                            input bit typed, input jbce_pkg::rsp_type want);
      while (may_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      compute_pin_phases(it);
      if (typed) begin
         void'(pending_phases.pop_back());
         pending_phases.push_back(want);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_cnt++;
   endtask

   // Mostly well-formed shift runs with random data, plus bitbang noise
   function automatic jbce_pkg::req_type draw_item();
      jbce_pkg::req_type it;
      int                pick;
      it.tdo_sample = 8'($urandom_range(0, 255));
      if (sh_active) begin
         it.host_byte = 8'($urandom_range(0, 255));
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            it.host_byte = {1'b0, 7'($urandom_range(0, 127))};
         end else begin
            it.host_byte                      = '0;
            it.host_byte[jbce_pkg::ShModeBit] = 1'b1;
            it.host_byte[jbce_pkg::ReadBit]   = 1'($urandom_range(0, 1));
            if (pick == 4)
               it.host_byte[jbce_pkg::CountW-1:0] = '0;
            else if (pick == 9)
               it.host_byte[jbce_pkg::CountW-1:0] = jbce_pkg::CountW'($urandom_range(5, 20));
            else
               it.host_byte[jbce_pkg::CountW-1:0] = jbce_pkg::CountW'($urandom_range(1, 4));
         end
      end
      return it;
   endfunction

   function automatic string phase_str(jbce_pkg::rsp_type p);
      return $sformatf("tck=%b tms=%b tdi=%b nce=%b ncs=%b led=%b rv=%b rb=%02h last=%b",
                       p.pin_tck, p.pin_tms, p.pin_tdi, p.pin_nce, p.pin_ncs,
                       p.pin_led, p.read_valid, p.read_byte, p.run_last);
   endfunction

   task automatic note_mismatch(input string what, input jbce_pkg::rsp_type want,
                                input jbce_pkg::rsp_type got);
      mismatch_cnt++;
      if (mismatch_cnt <= MaxReports) begin
         $display("mismatch at phase %0d:%s", phase_cnt, what);
         $display("   expected %s", phase_str(want));
         $display("   actual   %s", phase_str(got));
      end
   endtask

   // Compare each accepted phase with the oldest expectation
   always @(posedge clock) begin
      jbce_pkg::rsp_type want;
      string             bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_phases.size() == 0) begin
            note_mismatch(" no item expected", '0, rsp_item);
         end else begin
            want = pending_phases.pop_front();
            bad  = "";
            if (rsp_item.pin_tck !== want.pin_tck) bad = {bad, " pin_tck"};
            if (rsp_item.pin_tms !== want.pin_tms) bad = {bad, " pin_tms"};
            if (rsp_item.pin_tdi !== want.pin_tdi) bad = {bad, " pin_tdi"};
            if (rsp_item.pin_nce !== want.pin_nce) bad = {bad, " pin_nce"};
            if (rsp_item.pin_ncs !== want.pin_ncs) bad = {bad, " pin_ncs"};
            if (rsp_item.pin_led !== want.pin_led) bad = {bad, " pin_led"};
            if (rsp_item.read_valid !== want.read_valid) bad = {bad, " read_valid"};
            if (rsp_item.read_byte !== want.read_byte) bad = {bad, " read_byte"};
            if (rsp_item.run_last !== want.run_last) bad = {bad, " run_last"};
            if (bad != "") note_mismatch(bad, want, rsp_item);
         end
         phase_cnt++;
      end
   end

   // Drive rsp_ready: one long hold-off, a stall-free stretch, random stalls
   initial begin
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && sent_cnt >= 40) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         if (phase_cnt >= 600 && phase_cnt < 1100)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 99) >= 29);
         @(posedge clock);
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= StallLimit) begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Stimulus: directed table, then random items, then drain and verdict
   initial begin
      jbce_pkg::req_type it;
      while (reset) @(posedge clock);

      foreach (dir_tab[i]) begin
         it.host_byte  = dir_tab[i].host_byte;
         it.tdo_sample = dir_tab[i].tdo;
         send_item(it, 1'b1, dir_tab[i].typed,
                   pin_phase(dir_tab[i].pins, dir_tab[i].rv, dir_tab[i].rb, 1'b1));
      end

      for (int n = 0; n < RandItems; n++) begin
         // pause the sender until the engine has drained
         if (n == 100) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_phases.size() != 0) @(posedge clock);
         end
         send_item(draw_item(), !(n >= 140 && n < 200), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_phases.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);

      if (pending_phases.size() != 0) begin
         mismatch_cnt++;
         $display("%0d expected phases never arrived", pending_phases.size());
      end
      if (mismatch_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
